// ===== design/lowest_free_slot_allocator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LFSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfsa assertion failed");

// Next-cycle implication, disabled during reset
`define LFSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfsa assertion failed");

`endif

// ===== design/lfsa_pkg.sv =====
`timescale 1ns / 1ps

package lfsa_pkg;

    localparam int CLIENT_W = 8;
    localparam int SLOT_FW  = 6;
    localparam int COUNT_W  = 9;

    // Use counts saturate here
    localparam logic [COUNT_W-1:0] USE_MAX = 9'd256;

    typedef enum logic
    {
        KIND_ARRIVE = 1'b0,
        KIND_DEPART = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t               kind;
        logic [CLIENT_W-1:0] client;
    } req_t;

    typedef struct packed
    {
        logic [SLOT_FW-1:0] slot;
        logic               full_res;
        logic [COUNT_W-1:0] use_count;
    } rsp_t;

endpackage

// ===== design/lowest_free_slot_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  lfsa_pkg::req_t (kind, client)
// rsp       out        rsp_valid/rsp_stall  lfsa_pkg::rsp_t (slot, full_res, use_count)
//
// One transaction per cycle unless a result is held; stage 1, stage 2, then rsp_reg.
// The slot search over the free map and its update both happen in stage 1, so events
// issue back to back; the client table and use-count memory reads are pipelined
// around that step with bypass from the transaction just ahead.
// Reset frees every slot and clears all use counts at once (no clearing pass).
// A stalled result freezes the whole pipeline and req_stall rises in the same cycle.
module lowest_free_slot_allocator #(
    parameter int NUM_SLOTS   = 64,
    parameter int MAX_CLIENTS = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lfsa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lfsa_pkg::rsp_t rsp
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int HW_W   = $clog2(NUM_SLOTS + 1);
    localparam int CL_W   = $clog2(MAX_CLIENTS);
    localparam int TAB_N  = 2 ** lfsa_pkg::CLIENT_W;

    typedef logic [CL_W-1:0] cl_tab_t [TAB_N];

    // Map every client code onto its table row, wrapping past MAX_CLIENTS
    function automatic cl_tab_t build_cl_tab();
        cl_tab_t tab;
        for (int i = 0; i < TAB_N; i++)
        begin
            tab[i] = CL_W'(i % MAX_CLIENTS);
        end
        return tab;
    endfunction

    localparam cl_tab_t CL_TAB = build_cl_tab();

    // Storage
    logic [SLOT_W-1:0]           client_slot_mem [MAX_CLIENTS];
    logic [lfsa_pkg::COUNT_W-1:0] uses_mem [NUM_SLOTS];

    // Control state
    logic                 advance;
    logic                 s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [NUM_SLOTS-1:0] free_map_reg, free_map_next;
    logic [HW_W-1:0]      hw_reg, hw_next;

    // Stage 1: request plus client table read
    logic                 s1_kind_reg;
    logic [CL_W-1:0]      s1_client_reg;
    logic [SLOT_W-1:0]    s1_slot_rd_reg;
    logic                 s1_fwd_reg;
    logic [SLOT_W-1:0]    s1_fwd_slot_reg;

    // Stage 2: chosen slot plus use-count read
    logic [SLOT_W-1:0]            s2_slot_reg;
    logic                         s2_full_reg;
    logic                         s2_alloc_reg;
    logic [lfsa_pkg::COUNT_W-1:0] s2_cnt_rd_reg;
    logic                         s2_hit_reg;
    logic                         s2_fwd_reg;
    logic [lfsa_pkg::COUNT_W-1:0] s2_fwd_cnt_reg;

    lfsa_pkg::rsp_t rsp_reg, rsp_next;

    logic [CL_W-1:0]              cl_idx;
    logic [NUM_SLOTS-1:0]         low_onehot;
    logic [SLOT_W-1:0]            low_idx;
    logic                         found;
    logic                         arrive;
    logic                         alloc_ok;
    logic [SLOT_W-1:0]            dep_slot;
    logic [SLOT_W-1:0]            x_slot;
    logic                         cs_fwd_next;
    logic                         uses_fwd_next;
    logic [lfsa_pkg::COUNT_W-1:0] cnt_base;
    logic [lfsa_pkg::COUNT_W-1:0] cnt_new;

    // Move the whole pipeline unless a result is held
    assign advance   = !(out_valid_reg && rsp_stall);
    assign req_stall = !advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    assign cl_idx = CL_TAB[req.client];

    // Isolate the lowest free slot and encode it
    assign low_onehot = free_map_reg & (~free_map_reg + NUM_SLOTS'(1));
    assign found      = |free_map_reg;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (low_onehot[i])
            begin
                low_idx = low_idx | SLOT_W'(i);
            end
        end
    end

    // Resolve the transaction in stage 1
    assign arrive   = (s1_kind_reg == lfsa_pkg::KIND_ARRIVE);
    assign alloc_ok = s1_valid_reg && arrive && found;
    assign dep_slot = s1_fwd_reg ? s1_fwd_slot_reg : s1_slot_rd_reg;
    assign x_slot   = arrive ? low_idx : dep_slot;

    // Bypass a client table write to the request entering behind it
    assign cs_fwd_next   = alloc_ok && (cl_idx == s1_client_reg);
    // Bypass a use-count write to the slot entering stage 2 behind it
    assign uses_fwd_next = s2_valid_reg && s2_alloc_reg && (x_slot == s2_slot_reg);

    always_comb
    begin
        free_map_next = free_map_reg;
        if (advance && s1_valid_reg)
        begin
            if (alloc_ok)
            begin
                free_map_next[low_idx] = 1'b0;
            end
            if (!arrive)
            begin
                free_map_next[dep_slot] = 1'b1;
            end
        end
    end

    // Use count after this transaction; slots at or above the high-water mark read zero
    always_comb
    begin
        if (s2_fwd_reg)
        begin
            cnt_base = s2_fwd_cnt_reg;
        end
        else if (s2_hit_reg)
        begin
            cnt_base = s2_cnt_rd_reg;
        end
        else
        begin
            cnt_base = '0;
        end
        if (s2_alloc_reg && (cnt_base < lfsa_pkg::USE_MAX))
        begin
            cnt_new = cnt_base + lfsa_pkg::COUNT_W'(1);
        end
        else
        begin
            cnt_new = cnt_base;
        end
    end

    // Advance the high-water mark when a fresh slot is first taken
    always_comb
    begin
        hw_next = hw_reg;
        if (advance && s2_valid_reg && s2_alloc_reg && (HW_W'(s2_slot_reg) == hw_reg))
        begin
            hw_next = hw_reg + HW_W'(1);
        end
    end

    always_comb
    begin
        rsp_next.slot      = lfsa_pkg::SLOT_FW'(s2_slot_reg);
        rsp_next.full_res  = s2_full_reg;
        rsp_next.use_count = s2_full_reg ? '0 : cnt_new;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            free_map_reg  <= '1;
            hw_reg        <= '0;
        end
        else
        begin
            free_map_reg <= free_map_next;
            hw_reg       <= hw_next;
            if (advance)
            begin
                s1_valid_reg  <= req_valid;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Advance payload, client table and use-count memory
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg     <= req.kind;
            s1_client_reg   <= cl_idx;
            s1_slot_rd_reg  <= client_slot_mem[cl_idx];
            s1_fwd_reg      <= cs_fwd_next;
            s1_fwd_slot_reg <= low_idx;

            s2_slot_reg    <= x_slot;
            s2_full_reg    <= arrive && !found;
            s2_alloc_reg   <= arrive && found;
            s2_cnt_rd_reg  <= uses_mem[x_slot];
            s2_hit_reg     <= (HW_W'(x_slot) < hw_reg);
            s2_fwd_reg     <= uses_fwd_next;
            s2_fwd_cnt_reg <= cnt_new;

            rsp_reg <= rsp_next;

            if (alloc_ok)
            begin
                client_slot_mem[s1_client_reg] <= low_idx;
            end
            if (s2_valid_reg && s2_alloc_reg)
            begin
                uses_mem[s2_slot_reg] <= cnt_new;
            end
        end
    end

endmodule

// ===== design/lfsa_checker.sv =====
`timescale 1ns / 1ps
`include "lowest_free_slot_allocator_assert.svh"

module lfsa_props (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input lfsa_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lfsa_pkg::rsp_t rsp
);

    // A full arrival reports slot zero with no count
    `LFSA_ASSERT_NOW(a_full_zero, rsp_valid && rsp.full_res, {rsp.slot, rsp.use_count} == '0)

    // Use counts never pass saturation
    `LFSA_ASSERT_NOW(a_count_sat, rsp_valid, rsp.use_count <= lfsa_pkg::USE_MAX)

    // An empty output never backs up the request side
    `LFSA_ASSERT_NOW(a_no_idle_stall, !rsp_valid, !req_stall)

    // A held result stays put
    `LFSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // A stalled request stays put
    `LFSA_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req))

endmodule

bind lowest_free_slot_allocator lfsa_props u_lfsa_props (.*);
